### sv/tct_pkg.sv
// Package for the TCP connection table: state, command and status codes,
// flag bits and the controller/datapath command and status structs. No dependencies.
package tct_pkg;

    localparam int NUM_SLOTS = 16;

    typedef enum logic [2:0] {
        CONN_CLOSED      = 3'd0,
        CONN_SYN_SENT    = 3'd1,
        CONN_ESTABLISHED = 3'd2,
        CONN_FIN_WAIT_1  = 3'd3,
        CONN_CLOSE_WAIT  = 3'd4
    } conn_state_t;

    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_CONNECT = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_CLOSE   = 3'd3,
        CMD_SEGMENT = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD     = 2'd1,
        STS_FULL    = 2'd2,
        STS_DROPPED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_INIT_SEQ   = 2'd0,
        CFG_RX_WINDOW  = 2'd1,
        CFG_FIRST_PORT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        FSM_IDLE   = 3'd0,
        FSM_SEARCH = 3'd1,
        FSM_EXEC   = 3'd2,
        FSM_OUT    = 3'd3
    } fsm_state_t;

    localparam logic [7:0]  FL_FIN = 8'h01;
    localparam logic [7:0]  FL_SYN = 8'h02;
    localparam logic [7:0]  FL_PSH = 8'h08;
    localparam logic [7:0]  FL_ACK = 8'h10;
    localparam logic [15:0] HEADER_BYTES = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD  = 16'd65515;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic search;   // step one slot of the match search (newest first)
        logic exec;     // decide and update tables
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
    } dp_sts_t;

endpackage

### sv/tcp_connection_table_unit.sv
// Top level of the TCP connection table.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
// Usage:
//  - s_ channel: one request (command, slot, peer address/ports, flags,
//    sequence, length) accepted when s_valid && s_ready.
//  - m_ channel: exactly one result per request, held until m_ready.
//  - cfg channel: cfg_index/cfg_data, written when cfg_valid && cfg_ready;
//    always ready. Index 0 initial sequence, 1 receive window, 2 first
//    ephemeral port (also reloads the port counter). Write only while idle.
// Timing: one request at a time. After accept a command passes through the
//  SEARCH, EXEC and OUT states; its result is registered in EXEC and valid in
//  OUT. A received segment checks one slot per cycle, newest first, until a
//  slot matches or no slot is left, then goes on to EXEC. s_ready is high only
//  in the idle cycle: a new request waits until the last result has left.
// Reset (aresetn low, synchronous): all slots closed with zero ports and
//  address, no slots used, configuration back to its reset values.
// Stall: a result waits in its output registers while m_ready is low; no new
//  request is taken until it leaves.
module tcp_connection_table_unit
    import tct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_slot,
    input  logic [31:0] s_peer_ip,
    input  logic [15:0] s_peer_port,
    input  logic [15:0] s_dest_port,
    input  logic [7:0]  s_seg_flags,
    input  logic [31:0] s_seg_seq,
    input  logic [15:0] s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot_out,
    output logic        m_emit_valid,
    output logic [15:0] m_out_local_port,
    output logic [15:0] m_out_remote_port,
    output logic [31:0] m_out_ip,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_out_ack,
    output logic [7:0]  m_out_flags,
    output logic [15:0] m_out_window,
    output logic [15:0] m_out_payload_len
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    tct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    tct_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (dp_cmd),
        .sts               (dp_sts),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_command         (s_command),
        .s_slot            (s_slot),
        .s_peer_ip         (s_peer_ip),
        .s_peer_port       (s_peer_port),
        .s_dest_port       (s_dest_port),
        .s_seg_flags       (s_seg_flags),
        .s_seg_seq         (s_seg_seq),
        .s_length          (s_length),
        .m_status          (m_status),
        .m_slot_out        (m_slot_out),
        .m_emit_valid      (m_emit_valid),
        .m_out_local_port  (m_out_local_port),
        .m_out_remote_port (m_out_remote_port),
        .m_out_ip          (m_out_ip),
        .m_out_seq         (m_out_seq),
        .m_out_ack         (m_out_ack),
        .m_out_flags       (m_out_flags),
        .m_out_window      (m_out_window),
        .m_out_payload_len (m_out_payload_len)
    );

endmodule

### sv/tct_ctrl.sv
// Controller state machine of the TCP connection table.
// Depends on tct_pkg.
module tct_ctrl
    import tct_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.search_done) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = FSM_OUT;
            end
            FSM_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("accepting while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("exec not followed by result");

endmodule

### sv/tct_datapath.sv
// Datapath of the TCP connection table: slot tables, match search, updates, result.
// Depends on tct_pkg.
module tct_datapath
    import tct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [2:0]  s_command,
    input  logic [3:0]  s_slot,
    input  logic [31:0] s_peer_ip,
    input  logic [15:0] s_peer_port,
    input  logic [15:0] s_dest_port,
    input  logic [7:0]  s_seg_flags,
    input  logic [31:0] s_seg_seq,
    input  logic [15:0] s_length,
    output logic [1:0]  m_status,
    output logic [3:0]  m_slot_out,
    output logic        m_emit_valid,
    output logic [15:0] m_out_local_port,
    output logic [15:0] m_out_remote_port,
    output logic [31:0] m_out_ip,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_out_ack,
    output logic [7:0]  m_out_flags,
    output logic [15:0] m_out_window,
    output logic [15:0] m_out_payload_len
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    // configuration
    logic [31:0] init_seq_reg;
    logic [15:0] rx_window_reg;
    logic [15:0] eph_reg;

    // slot tables
    conn_state_t st_reg   [NUM_SLOTS];
    logic [15:0] lport_reg[NUM_SLOTS];
    logic [15:0] rport_reg[NUM_SLOTS];
    logic [31:0] rip_reg  [NUM_SLOTS];
    logic [31:0] seq_reg  [NUM_SLOTS];
    logic [31:0] ack_reg  [NUM_SLOTS];
    logic [15:0] win_reg  [NUM_SLOTS];
    logic [CW-1:0] used_reg;

    // captured request
    logic [2:0]  c_cmd_reg;
    logic [3:0]  c_slot_reg;
    logic [31:0] c_ip_reg;
    logic [15:0] c_pport_reg, c_dport_reg, c_len_reg;
    logic [7:0]  c_flags_reg;
    logic [31:0] c_seq_reg;

    // search
    logic [CW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] match_reg;

    logic [IW-1:0] cur;
    logic          hit;
    assign cur = IW'(idx_reg - CW'(1));
    assign hit = (idx_reg != '0) && lport_reg[cur] == c_dport_reg
              && rport_reg[cur] == c_pport_reg && rip_reg[cur] == c_ip_reg;
    assign sts.search_done = (c_cmd_reg != CMD_SEGMENT) || found_reg
                          || idx_reg == '0 || hit;

    // execution decode
    logic [IW-1:0] ts;
    logic          slot_ok;
    always_comb begin
        if (c_cmd_reg == CMD_SEGMENT) ts = match_reg;
        else ts = IW'(c_slot_reg);
        slot_ok = ({1'b0, c_slot_reg} < used_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_seq_reg  <= 32'h12345678;
            rx_window_reg <= 16'd65535;
            eph_reg       <= 16'd49152;
            used_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                st_reg[i]    <= CONN_CLOSED;
                lport_reg[i] <= '0;
                rport_reg[i] <= '0;
                rip_reg[i]   <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_INIT_SEQ:   init_seq_reg  <= cfg_data;
                    CFG_RX_WINDOW:  rx_window_reg <= cfg_data[15:0];
                    CFG_FIRST_PORT: eph_reg       <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                c_cmd_reg   <= s_command;
                c_slot_reg  <= s_slot;
                c_ip_reg    <= s_peer_ip;
                c_pport_reg <= s_peer_port;
                c_dport_reg <= s_dest_port;
                c_flags_reg <= s_seg_flags;
                c_seq_reg   <= s_seg_seq;
                c_len_reg   <= s_length;
                idx_reg     <= used_reg;
                found_reg   <= 1'b0;
            end
            if (cmd.search && !found_reg && idx_reg != '0) begin
                if (hit) begin
                    found_reg <= 1'b1;
                    match_reg <= cur;
                end else begin
                    idx_reg <= idx_reg - CW'(1);
                end
            end
            if (cmd.exec) begin
                m_status          <= STS_OK;
                m_slot_out        <= '0;
                m_emit_valid      <= 1'b0;
                m_out_local_port  <= '0;
                m_out_remote_port <= '0;
                m_out_ip          <= '0;
                m_out_seq         <= '0;
                m_out_ack         <= '0;
                m_out_flags       <= '0;
                m_out_window      <= '0;
                m_out_payload_len <= '0;
                case (c_cmd_reg)
                    CMD_CREATE: begin
                        if (used_reg >= CW'(NUM_SLOTS)) begin
                            m_status <= STS_FULL;
                        end else begin
                            st_reg[IW'(used_reg)]    <= CONN_CLOSED;
                            lport_reg[IW'(used_reg)] <= '0;
                            rport_reg[IW'(used_reg)] <= '0;
                            rip_reg[IW'(used_reg)]   <= '0;
                            seq_reg[IW'(used_reg)]   <= init_seq_reg;
                            ack_reg[IW'(used_reg)]   <= '0;
                            win_reg[IW'(used_reg)]   <= rx_window_reg;
                            used_reg                 <= used_reg + CW'(1);
                            m_slot_out               <= 4'(used_reg);
                        end
                    end
                    CMD_CONNECT, CMD_SEND, CMD_CLOSE: begin
                        m_slot_out <= c_slot_reg;
                        if (!slot_ok) begin
                            m_status <= STS_BAD;
                        end else if (c_cmd_reg == CMD_CONNECT) begin
                            if (st_reg[ts] != CONN_CLOSED) begin
                                m_status <= STS_BAD;
                            end else begin
                                rip_reg[ts]       <= c_ip_reg;
                                rport_reg[ts]     <= c_pport_reg;
                                lport_reg[ts]     <= eph_reg;
                                eph_reg           <= eph_reg + 16'd1;
                                st_reg[ts]        <= CONN_SYN_SENT;
                                m_emit_valid      <= 1'b1;
                                m_out_local_port  <= eph_reg;
                                m_out_remote_port <= c_pport_reg;
                                m_out_ip          <= c_ip_reg;
                                m_out_seq         <= seq_reg[ts];
                                m_out_ack         <= ack_reg[ts];
                                m_out_flags       <= FL_SYN;
                                m_out_window      <= win_reg[ts];
                                seq_reg[ts]       <= seq_reg[ts] + 32'd1;
                            end
                        end else if (st_reg[ts] != CONN_ESTABLISHED
                                  || (c_cmd_reg == CMD_SEND && c_len_reg > MAX_PAYLOAD)) begin
                            m_status <= STS_BAD;
                        end else begin
                            m_emit_valid      <= 1'b1;
                            m_out_local_port  <= lport_reg[ts];
                            m_out_remote_port <= rport_reg[ts];
                            m_out_ip          <= rip_reg[ts];
                            m_out_seq         <= seq_reg[ts];
                            m_out_ack         <= ack_reg[ts];
                            m_out_window      <= win_reg[ts];
                            if (c_cmd_reg == CMD_SEND) begin
                                m_out_flags       <= FL_ACK | FL_PSH;
                                m_out_payload_len <= c_len_reg;
                                seq_reg[ts] <= seq_reg[ts] + {16'd0, c_len_reg};
                            end else begin
                                m_out_flags <= FL_FIN | FL_ACK;
                                seq_reg[ts] <= seq_reg[ts] + 32'd1;
                                st_reg[ts]  <= CONN_FIN_WAIT_1;
                            end
                        end
                    end
                    CMD_SEGMENT: begin
                        if (c_len_reg < HEADER_BYTES || !found_reg) begin
                            m_status <= STS_DROPPED;
                        end else begin
                            m_slot_out <= 4'(match_reg);
                            if ((st_reg[ts] == CONN_SYN_SENT
                                 && (c_flags_reg & FL_SYN) != '0
                                 && (c_flags_reg & FL_ACK) != '0)
                             || (st_reg[ts] == CONN_ESTABLISHED
                                 && (c_flags_reg & FL_FIN) != '0)) begin
                                ack_reg[ts]       <= c_seq_reg + 32'd1;
                                st_reg[ts]        <= (st_reg[ts] == CONN_SYN_SENT)
                                                     ? CONN_ESTABLISHED : CONN_CLOSE_WAIT;
                                m_emit_valid      <= 1'b1;
                                m_out_local_port  <= lport_reg[ts];
                                m_out_remote_port <= rport_reg[ts];
                                m_out_ip          <= rip_reg[ts];
                                m_out_seq         <= seq_reg[ts];
                                m_out_ack         <= c_seq_reg + 32'd1;
                                m_out_flags       <= FL_ACK;
                                m_out_window      <= win_reg[ts];
                            end
                        end
                    end
                    default: m_status <= STS_DROPPED;
                endcase
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(NUM_SLOTS))
        else $error("slot count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && c_cmd_reg == CMD_CREATE && used_reg < CW'(NUM_SLOTS)
        |=> used_reg == $past(used_reg) + CW'(1))
        else $error("create did not take a slot");
    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> idx_reg != '0)
        else $error("match beyond table");

endmodule
